[rtl/scsr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the stencil CSR row builder.
// No dependencies; every other file of the block depends on this package.
package scsr_pkg;

	localparam int COEFF_W     = 32;
	localparam int COL_W       = 24;
	localparam int VAL_W       = 36;
	localparam int CNT_W       = 27;
	localparam int GRID_REG_W  = 9;
	localparam int MODES_W     = 12;
	localparam int NUM_SIDES   = 6;
	localparam int NUM_ENTRIES = 7;
	localparam int DIAG_SLOT   = 6;
	localparam int SLOT_W      = 3;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef logic        [COL_W-1:0]   col_t;
	typedef logic signed [VAL_W-1:0]   val_t;
	typedef logic        [CNT_W-1:0]   cnt_t;
	typedef logic        [SLOT_W-1:0]  slot_t;

	// Register map, one 32-bit word each.
	typedef enum logic [1:0] {
		REG_GRID_X         = 2'd0,
		REG_GRID_Y         = 2'd1,
		REG_GRID_Z         = 2'd2,
		REG_BOUNDARY_MODES = 2'd3
	} reg_index_t;

	// Boundary condition per side; the unused code behaves as Neumann.
	typedef enum logic [1:0] {
		MODE_PERIODIC  = 2'd0,
		MODE_DIRICHLET = 2'd1,
		MODE_NEUMANN   = 2'd2
	} bc_mode_t;

	// Side order: x-low, x-high, y-low, y-high, z-low, z-high.
	localparam int SIDE_XLO = 0;
	localparam int SIDE_XHI = 1;
	localparam int SIDE_YLO = 2;
	localparam int SIDE_YHI = 3;
	localparam int SIDE_ZLO = 4;
	localparam int SIDE_ZHI = 5;

endpackage

[rtl/scsr_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the stencil CSR row builder: cell requests in,
// matrix entries out. Depends on scsr_pkg for the payload types.
interface scsr_cell_if;
	logic            valid;
	logic            ready;
	scsr_pkg::coeff_t centre_coeff;
	scsr_pkg::coeff_t east_coeff;
	scsr_pkg::coeff_t west_coeff;
	scsr_pkg::coeff_t north_coeff;
	scsr_pkg::coeff_t south_coeff;
	scsr_pkg::coeff_t top_coeff;
	scsr_pkg::coeff_t bottom_coeff;

	modport source (
		output valid, centre_coeff, east_coeff, west_coeff, north_coeff,
		       south_coeff, top_coeff, bottom_coeff,
		input  ready
	);
	modport sink (
		input  valid, centre_coeff, east_coeff, west_coeff, north_coeff,
		       south_coeff, top_coeff, bottom_coeff,
		output ready
	);
endinterface

interface scsr_entry_if;
	logic            valid;
	logic            ready;
	scsr_pkg::col_t  column;
	scsr_pkg::val_t  entry_value;
	logic            row_last;
	scsr_pkg::cnt_t  row_end;

	modport source (
		output valid, column, entry_value, row_last, row_end,
		input  ready
	);
	modport sink (
		input  valid, column, entry_value, row_last, row_end,
		output ready
	);
endinterface

[rtl/stencil_csr_row_builder_unit.sv]
`timescale 1ns / 1ps
// Seven-point stencil CSR row builder, top level.
// Depends on scsr_pkg and the channel interfaces in scsr_if.sv.
//
// Usage:
//   cells   - one request per grid cell in raster order (x fastest), carrying
//             the centre and six face coefficients, signed Q16.16.
//   entries - the cell's CSR row, one to seven (column, value) entries in
//             ascending column order; row_last marks the final entry and
//             row_end carries the running entry count after the row.
//   APB     - grid_x, grid_y, grid_z, boundary_modes at byte offsets 0,4,8,12.
//             Write only while the block is idle. A grid write restarts the
//             frame at cell (0,0,0).
// The first entry of a row shows on entries once its accepted cell request
//   has passed the input stage (loaded at the accepting edge), then the
//   column/sum stage, then the row buffer.
// A cell occupies the single output port until every entry of its row has
//   left; an interior cell's row has seven entries. The row buffer reloads
//   in the cycle its last entry leaves.
// Reset, and each grid write, hold cells.ready low while the plane and
//   wrap strides are recomputed through their multipliers.
// When the receiver stalls, the row buffer holds its entry, the two stages
//   behind it fill, and cells.ready drops until the buffer moves again.
module stencil_csr_row_builder_unit #(
	parameter int MAX_EXTENT = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [scsr_pkg::ADDR_W-1:0] paddr,
	input  logic [scsr_pkg::DATA_W-1:0] pwdata,
	output logic [scsr_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	scsr_cell_if.sink                  cells,
	scsr_entry_if.source               entries
);
	import scsr_pkg::*;

	localparam int EXT_W = $clog2(MAX_EXTENT + 1);
	localparam int POS_W = $clog2(MAX_EXTENT);

	// Clamp a raw grid register to 1..MAX_EXTENT.
	function automatic logic [EXT_W-1:0] clamp_extent(input logic [GRID_REG_W-1:0] v);
		if (v == '0) begin
			return EXT_W'(1);
		end else if (32'(v) > MAX_EXTENT) begin
			return EXT_W'(MAX_EXTENT);
		end else begin
			return EXT_W'(v);
		end
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [GRID_REG_W-1:0] grid_x_q, grid_y_q, grid_z_q;
	logic [MODES_W-1:0]    boundary_modes_q;
	logic                  cfg_wr;
	logic                  grid_wr;
	reg_index_t            cfg_index;

	assign pready    = 1'b1;
	assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr    = psel & penable & pwrite;
	assign grid_wr   = cfg_wr & (cfg_index != REG_BOUNDARY_MODES);

	always_comb begin
		unique case (cfg_index)
			REG_GRID_X:         prdata = DATA_W'(grid_x_q);
			REG_GRID_Y:         prdata = DATA_W'(grid_y_q);
			REG_GRID_Z:         prdata = DATA_W'(grid_z_q);
			REG_BOUNDARY_MODES: prdata = DATA_W'(boundary_modes_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q         <= GRID_REG_W'(1);
			grid_y_q         <= GRID_REG_W'(1);
			grid_z_q         <= GRID_REG_W'(1);
			boundary_modes_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_GRID_X:         grid_x_q         <= pwdata[GRID_REG_W-1:0];
				REG_GRID_Y:         grid_y_q         <= pwdata[GRID_REG_W-1:0];
				REG_GRID_Z:         grid_z_q         <= pwdata[GRID_REG_W-1:0];
				REG_BOUNDARY_MODES: boundary_modes_q <= pwdata[MODES_W-1:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Grid extents and column strides
	// ------------------------------------------------------------------
	logic [EXT_W-1:0]       nx, ny, nz;
	logic [POS_W-1:0]       nx_m1, ny_m1, nz_m1;
	col_t                   nx_col, xwrap;
	logic [2*EXT_W-1:0]     plane_full;
	logic [COL_W+EXT_W-1:0] zwrap_full;
	col_t                   plane_q, ywrap_q, zwrap_q;
	logic [1:0]             settle_q;

	assign nx         = clamp_extent(grid_x_q);
	assign ny         = clamp_extent(grid_y_q);
	assign nz         = clamp_extent(grid_z_q);
	assign nx_m1      = POS_W'(nx - EXT_W'(1));
	assign ny_m1      = POS_W'(ny - EXT_W'(1));
	assign nz_m1      = POS_W'(nz - EXT_W'(1));
	assign nx_col     = COL_W'(nx);
	assign xwrap      = COL_W'(nx_m1);
	assign plane_full = nx * ny;
	assign zwrap_full = plane_q * (COL_W + EXT_W)'(nz_m1);

	// Plane size first, then the y and z wrap distances from it.
	always_ff @(posedge clk) begin
		plane_q <= COL_W'(plane_full);
		ywrap_q <= plane_q - nx_col;
		zwrap_q <= zwrap_full[COL_W-1:0];
	end

	// Hold off requests until the stride registers have caught up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 2'd2;
		end else if (grid_wr) begin
			settle_q <= 2'd2;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// ------------------------------------------------------------------
	// Handshake chain: row buffer <- stage 2 <- stage 1 <- cells
	// ------------------------------------------------------------------
	logic  valid_s1, valid_s2, buf_valid_q;
	slot_t buf_idx_q, buf_cnt_q;
	logic  buf_at_last, out_fire, row_done, buf_load, adv_s2, adv_s1, accept;

	assign buf_at_last   = (buf_idx_q == buf_cnt_q - SLOT_W'(1));
	assign out_fire      = buf_valid_q & entries.ready;
	assign row_done      = out_fire & buf_at_last;
	assign buf_load      = valid_s2 & (~buf_valid_q | row_done);
	assign adv_s2        = ~valid_s2 | buf_load;
	assign adv_s1        = valid_s1 & adv_s2;
	assign cells.ready   = (~valid_s1 | adv_s2) & (settle_q == 2'd0);
	assign accept        = cells.valid & cells.ready;

	// ------------------------------------------------------------------
	// Position tracking at request time
	// ------------------------------------------------------------------
	logic [POS_W-1:0]     x_pos_q, y_pos_q, z_pos_q;
	col_t                 row_index_q;
	logic                 last_x, last_y, last_z, frame_end;
	logic [NUM_SIDES-1:0] at_edge;

	assign last_x    = (x_pos_q == nx_m1);
	assign last_y    = (y_pos_q == ny_m1);
	assign last_z    = (z_pos_q == nz_m1);
	assign frame_end = last_x & last_y & last_z;

	always_comb begin
		at_edge[SIDE_XLO] = (x_pos_q == '0);
		at_edge[SIDE_XHI] = last_x;
		at_edge[SIDE_YLO] = (y_pos_q == '0);
		at_edge[SIDE_YHI] = last_y;
		at_edge[SIDE_ZLO] = (z_pos_q == '0);
		at_edge[SIDE_ZHI] = last_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_pos_q     <= '0;
			y_pos_q     <= '0;
			z_pos_q     <= '0;
			row_index_q <= '0;
		end else if (grid_wr || (accept && frame_end)) begin
			// restart the frame
			x_pos_q     <= '0;
			y_pos_q     <= '0;
			z_pos_q     <= '0;
			row_index_q <= '0;
		end else if (accept) begin
			row_index_q <= row_index_q + COL_W'(1);
			if (last_x) begin
				x_pos_q <= '0;
				if (last_y) begin
					y_pos_q <= '0;
					z_pos_q <= z_pos_q + POS_W'(1);
				end else begin
					y_pos_q <= y_pos_q + POS_W'(1);
				end
			end else begin
				x_pos_q <= x_pos_q + POS_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the accepted request
	// ------------------------------------------------------------------
	coeff_t               centre_s1;
	coeff_t               face_s1 [NUM_SIDES];
	logic [NUM_SIDES-1:0] edge_s1;
	col_t                 row_s1;
	logic                 frame_last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			centre_s1          <= cells.centre_coeff;
			face_s1[SIDE_XLO]  <= cells.west_coeff;
			face_s1[SIDE_XHI]  <= cells.east_coeff;
			face_s1[SIDE_YLO]  <= cells.south_coeff;
			face_s1[SIDE_YHI]  <= cells.north_coeff;
			face_s1[SIDE_ZLO]  <= cells.bottom_coeff;
			face_s1[SIDE_ZHI]  <= cells.top_coeff;
			edge_s1            <= at_edge;
			row_s1             <= row_index_q;
			frame_last_s1      <= frame_end;
		end
	end

	// Neighbor columns, kept entries and diagonal partial sums.
	col_t                   col_c  [NUM_ENTRIES];
	val_t                   term_c [NUM_SIDES];
	logic [NUM_ENTRIES-1:0] keep_c;
	val_t                   part_a_c, part_b_c;

	always_comb begin
		col_c[SIDE_XLO]  = edge_s1[SIDE_XLO] ? row_s1 + xwrap   : row_s1 - COL_W'(1);
		col_c[SIDE_XHI]  = edge_s1[SIDE_XHI] ? row_s1 - xwrap   : row_s1 + COL_W'(1);
		col_c[SIDE_YLO]  = edge_s1[SIDE_YLO] ? row_s1 + ywrap_q : row_s1 - nx_col;
		col_c[SIDE_YHI]  = edge_s1[SIDE_YHI] ? row_s1 - ywrap_q : row_s1 + nx_col;
		col_c[SIDE_ZLO]  = edge_s1[SIDE_ZLO] ? row_s1 + zwrap_q : row_s1 - plane_q;
		col_c[SIDE_ZHI]  = edge_s1[SIDE_ZHI] ? row_s1 - zwrap_q : row_s1 + plane_q;
		col_c[DIAG_SLOT] = row_s1;
	end

	// Each face enters the diagonal once; a Dirichlet edge takes it twice,
	// a Neumann edge cancels it.
	always_comb begin
		keep_c[DIAG_SLOT] = 1'b1;
		for (int s = 0; s < NUM_SIDES; s++) begin
			keep_c[s] = 1'b1;
			term_c[s] = val_t'(face_s1[s]);
			if (edge_s1[s]) begin
				unique case (bc_mode_t'(boundary_modes_q[2*s +: 2]))
					MODE_PERIODIC: begin
						term_c[s] = val_t'(face_s1[s]);
					end
					MODE_DIRICHLET: begin
						keep_c[s] = 1'b0;
						term_c[s] = val_t'(face_s1[s]) <<< 1;
					end
					default: begin
						keep_c[s] = 1'b0;
						term_c[s] = '0;
					end
				endcase
			end
		end
		part_a_c = val_t'(centre_s1) - (term_c[SIDE_XLO] + term_c[SIDE_XHI]);
		part_b_c = (term_c[SIDE_YLO] + term_c[SIDE_YHI])
		         + (term_c[SIDE_ZLO] + term_c[SIDE_ZHI]);
	end

	// ------------------------------------------------------------------
	// Stage 2: columns and values ready for sorting
	// ------------------------------------------------------------------
	col_t                   col_s2  [NUM_ENTRIES];
	val_t                   face_s2 [NUM_SIDES];
	logic [NUM_ENTRIES-1:0] keep_s2;
	val_t                   part_a_s2, part_b_s2;
	logic                   frame_last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (buf_load) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			col_s2        <= col_c;
			for (int s = 0; s < NUM_SIDES; s++) begin
				face_s2[s] <= val_t'(face_s1[s]);
			end
			keep_s2       <= keep_c;
			part_a_s2     <= part_a_c;
			part_b_s2     <= part_b_c;
			frame_last_s2 <= frame_last_s1;
		end
	end

	// Stable rank of each kept entry: smaller columns first, ties in
	// generation order. Scatter entries into their row slots.
	val_t  entry_val_c [NUM_ENTRIES];
	slot_t rank_c      [NUM_ENTRIES];
	slot_t row_cnt_c;
	col_t  load_col_c  [NUM_ENTRIES];
	val_t  load_val_c  [NUM_ENTRIES];
	cnt_t  row_end_c;

	always_comb begin
		for (int s = 0; s < NUM_SIDES; s++) begin
			entry_val_c[s] = face_s2[s];
		end
		entry_val_c[DIAG_SLOT] = part_a_s2 - part_b_s2;

		row_cnt_c = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			row_cnt_c = row_cnt_c + SLOT_W'(keep_s2[i]);
			rank_c[i] = '0;
			for (int j = 0; j < NUM_ENTRIES; j++) begin
				if (j != i && keep_s2[j] && ((col_s2[j] < col_s2[i])
				    || (col_s2[j] == col_s2[i] && j < i))) begin
					rank_c[i] = rank_c[i] + SLOT_W'(1);
				end
			end
		end

		for (int d = 0; d < NUM_ENTRIES; d++) begin
			load_col_c[d] = '0;
			load_val_c[d] = '0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (keep_s2[i] && rank_c[i] == SLOT_W'(d)) begin
					load_col_c[d] = col_s2[i];
					load_val_c[d] = entry_val_c[i];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Row buffer and running entry count
	// ------------------------------------------------------------------
	col_t buf_col_q [NUM_ENTRIES];
	val_t buf_val_q [NUM_ENTRIES];
	cnt_t buf_end_q;
	cnt_t entry_count_q;

	assign row_end_c = entry_count_q + CNT_W'(row_cnt_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q   <= 1'b0;
			buf_idx_q     <= '0;
			buf_cnt_q     <= SLOT_W'(1);
			entry_count_q <= '0;
		end else begin
			if (buf_load) begin
				buf_valid_q <= 1'b1;
				buf_idx_q   <= '0;
				buf_cnt_q   <= row_cnt_c;
			end else if (row_done) begin
				buf_valid_q <= 1'b0;
			end else if (out_fire) begin
				buf_idx_q <= buf_idx_q + SLOT_W'(1);
			end

			// drop the count at a new frame
			if (grid_wr) begin
				entry_count_q <= '0;
			end else if (buf_load) begin
				entry_count_q <= frame_last_s2 ? '0 : row_end_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (buf_load) begin
			buf_col_q <= load_col_c;
			buf_val_q <= load_val_c;
			buf_end_q <= row_end_c;
		end
	end

	assign entries.valid       = buf_valid_q;
	assign entries.column      = buf_col_q[buf_idx_q];
	assign entries.entry_value = buf_val_q[buf_idx_q];
	assign entries.row_last    = buf_at_last;
	assign entries.row_end     = buf_end_q;

endmodule

[rtl/scsr_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the stencil CSR row builder and their bind.
// Depends on scsr_pkg and stencil_csr_row_builder_unit.
module scsr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input scsr_pkg::col_t              column,
	input scsr_pkg::val_t              entry_value,
	input logic                        row_last,
	input scsr_pkg::cnt_t              row_end,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [scsr_pkg::ADDR_W-1:0] paddr
);
	import scsr_pkg::*;

	logic out_fire;
	logic grid_write;

	assign out_fire   = out_valid & out_ready;
	assign grid_write = psel & penable & pwrite
	                  & (paddr[ADDR_W-1:2] != REG_BOUNDARY_MODES);

	// Hold a stalled entry.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(column)
		&& $stable(entry_value) && $stable(row_last) && $stable(row_end))
		else $error("stalled entry changed");

	// A row continues without a gap and keeps its row pointer.
	a_row_end_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !row_last |=> out_valid && row_end == $past(row_end))
		else $error("row pointer changed inside a row");

	// Columns ascend within a row.
	a_row_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !row_last |=> column >= $past(column))
		else $error("row entries out of column order");

	// A grid write blocks requests while strides settle.
	a_grid_settle: assert property (@(posedge clk) disable iff (!arst_n)
		grid_write |=> !in_ready)
		else $error("request taken right after a grid write");

endmodule

bind stencil_csr_row_builder_unit scsr_checker u_scsr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (cells.ready),
	.out_valid   (entries.valid),
	.out_ready   (entries.ready),
	.column      (entries.column),
	.entry_value (entries.entry_value),
	.row_last    (entries.row_last),
	.row_end     (entries.row_end),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr)
);

[sim/scsr_row_checker.sv]
`timescale 1ns / 1ps
// Row checker for the stencil CSR row builder: snoops APB writes and both channels,
// predicts each cell's CSR row and compares every entry. Depends on scsr_pkg and scsr_if.sv.
module scsr_row_checker #(
	parameter int MAX_EXTENT = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [scsr_pkg::ADDR_W-1:0] paddr,
	input  logic [scsr_pkg::DATA_W-1:0] pwdata,
	scsr_cell_if                       cells,
	scsr_entry_if                      entries,
	output int                         fail_count,
	output int                         pending_entries
);
	import scsr_pkg::*;

	typedef struct packed {
		col_t column;
		val_t entry_value;
		logic row_last;
		cnt_t row_end;
	} row_entry_t;

	logic [GRID_REG_W-1:0] grid_x_reg, grid_y_reg, grid_z_reg;
	logic [MODES_W-1:0]    modes_reg;
	logic [7:0]            x_pos, y_pos, z_pos;
	cnt_t                  entry_total;

	row_entry_t pending_row_entries[$];
	row_entry_t want;
	coeff_t     faces [NUM_SIDES];
	int         errors;
	int         reported;

	function automatic int eff_extent(logic [GRID_REG_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_EXTENT)
			return MAX_EXTENT;
		return int'(v);
	endfunction

	function automatic col_t cell_index(int x, int y, int z, int nx, int ny);
		return col_t'((z * ny + y) * nx + x);
	endfunction

	function automatic void restart_frame();
		x_pos = '0;
		y_pos = '0;
		z_pos = '0;
		entry_total = '0;
	endfunction

	// Work out one cell's sorted row from the current position and registers.
	function automatic void build_row(coeff_t centre);
		int nx, ny, nz, x, y, z, n, i, j;
		col_t cols [NUM_ENTRIES];
		longint vals [NUM_ENTRIES];
		longint diag, face;
		logic [1:0] mode;
		bit at_edge;
		col_t nbr, ct;
		longint vt;
		row_entry_t item;
		nx = eff_extent(grid_x_reg);
		ny = eff_extent(grid_y_reg);
		nz = eff_extent(grid_z_reg);
		x = int'(x_pos);
		y = int'(y_pos);
		z = int'(z_pos);
		diag = longint'(centre);
		for (int s = 0; s < NUM_SIDES; s++)
			diag -= longint'(faces[s]);
		n = 0;
		for (int s = 0; s < NUM_SIDES; s++) begin
			mode = modes_reg[2*s +: 2];
			face = longint'(faces[s]);
			case (s)
				SIDE_XLO: begin
					at_edge = (x == 0);
					nbr = cell_index(x == 0 ? nx - 1 : x - 1, y, z, nx, ny);
				end
				SIDE_XHI: begin
					at_edge = (x == nx - 1);
					nbr = cell_index(x + 1 >= nx ? 0 : x + 1, y, z, nx, ny);
				end
				SIDE_YLO: begin
					at_edge = (y == 0);
					nbr = cell_index(x, y == 0 ? ny - 1 : y - 1, z, nx, ny);
				end
				SIDE_YHI: begin
					at_edge = (y == ny - 1);
					nbr = cell_index(x, y + 1 >= ny ? 0 : y + 1, z, nx, ny);
				end
				SIDE_ZLO: begin
					at_edge = (z == 0);
					nbr = cell_index(x, y, z == 0 ? nz - 1 : z - 1, nx, ny);
				end
				default: begin
					at_edge = (z == nz - 1);
					nbr = cell_index(x, y, z + 1 >= nz ? 0 : z + 1, nx, ny);
				end
			endcase
			if (at_edge && mode != MODE_PERIODIC) begin
				// code 3 folds like Neumann
				if (mode == MODE_DIRICHLET)
					diag -= face;
				else
					diag += face;
			end else begin
				cols[n] = nbr;
				vals[n] = face;
				n++;
			end
		end
		cols[n] = cell_index(x, y, z, nx, ny);
		vals[n] = diag;
		n++;

		// stable insertion sort: equal columns keep generation order
		for (i = 1; i < n; i++) begin
			ct = cols[i];
			vt = vals[i];
			j = i - 1;
			while (j >= 0 && cols[j] > ct) begin
				cols[j + 1] = cols[j];
				vals[j + 1] = vals[j];
				j--;
			end
			cols[j + 1] = ct;
			vals[j + 1] = vt;
		end

		entry_total = entry_total + cnt_t'(n);
		for (i = 0; i < n; i++) begin
			item = '{cols[i], val_t'(vals[i]), i == n - 1, entry_total};
			pending_row_entries = {pending_row_entries, item};
		end

		x++;
		if (x >= nx) begin
			x = 0;
			y++;
			if (y >= ny) begin
				y = 0;
				z++;
			end
		end
		if (z >= nz) begin
			restart_frame();
		end else begin
			x_pos = 8'(x);
			y_pos = 8'(y);
			z_pos = 8'(z);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_reg = GRID_REG_W'(1);
			grid_y_reg = GRID_REG_W'(1);
			grid_z_reg = GRID_REG_W'(1);
			modes_reg = '0;
			restart_frame();
			pending_row_entries.delete();
			errors = 0;
			reported = 0;
			fail_count <= 0;
			pending_entries <= 0;
		end else begin
			// retire first: an entry never belongs to a cell taken at the same edge
			if (entries.valid && entries.ready) begin
				if (pending_row_entries.size() == 0) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("unexpected entry: column %0d value %0d last %0b row_end %0d",
							entries.column, entries.entry_value, entries.row_last,
							entries.row_end);
					end
				end else begin
					want = pending_row_entries.pop_front();
					if (entries.column !== want.column || entries.entry_value !== want.entry_value
							|| entries.row_last !== want.row_last
							|| entries.row_end !== want.row_end) begin
						errors++;
						if (reported < 10) begin
							reported++;
							$display("entry mismatch: column %0d/%0d value %0d/%0d last %0b/%0b row_end %0d/%0d (exp/got)",
								want.column, entries.column, want.entry_value,
								entries.entry_value, want.row_last, entries.row_last,
								want.row_end, entries.row_end);
						end
					end
				end
			end

			if (cells.valid && cells.ready) begin
				faces[SIDE_XLO] = cells.west_coeff;
				faces[SIDE_XHI] = cells.east_coeff;
				faces[SIDE_YLO] = cells.south_coeff;
				faces[SIDE_YHI] = cells.north_coeff;
				faces[SIDE_ZLO] = cells.bottom_coeff;
				faces[SIDE_ZHI] = cells.top_coeff;
				build_row(cells.centre_coeff);
			end

			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[ADDR_W-1:2]))
					REG_GRID_X: begin
						grid_x_reg = pwdata[GRID_REG_W-1:0];
						restart_frame();
					end
					REG_GRID_Y: begin
						grid_y_reg = pwdata[GRID_REG_W-1:0];
						restart_frame();
					end
					REG_GRID_Z: begin
						grid_z_reg = pwdata[GRID_REG_W-1:0];
						restart_frame();
					end
					REG_BOUNDARY_MODES: modes_reg = pwdata[MODES_W-1:0];
					default: ;
				endcase
			end

			fail_count <= errors;
			pending_entries <= pending_row_entries.size();
		end
	end

endmodule

[sim/stencil_csr_row_builder_unit_test.sv]
`timescale 1ns / 1ps
// Testbench top for the stencil CSR row builder: drives cell requests, APB writes and
// entry back-pressure, and gives the verdict. Depends on scsr_pkg, scsr_if.sv, scsr_row_checker.
module stencil_csr_row_builder_unit_test;
	import scsr_pkg::*;

	localparam int MAX_EXTENT      = 256;
	localparam int IDLE_PCT        = 22;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int STALL_LIMIT     = 2000;
	localparam int SETTLE_CYCLES   = 10;
	localparam int RANDOM_CELLS    = 105;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	scsr_cell_if  cell_req ();
	scsr_entry_if row_entry ();

	int fail_count;
	int pending_entries;
	int stall_cycles;
	int hold_left;
	bit quiet;          // no idling on either side while set
	bit hold_off_req;   // ask the receiver for one long hold-off

	stencil_csr_row_builder_unit #(
		.MAX_EXTENT(MAX_EXTENT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cells   (cell_req),
		.entries (row_entry)
	);

	scsr_row_checker #(
		.MAX_EXTENT(MAX_EXTENT)
	) row_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.cells           (cell_req),
		.entries         (row_entry),
		.fail_count      (fail_count),
		.pending_entries (pending_entries)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: end the run when nothing moves on any port for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((cell_req.valid && cell_req.ready) || (row_entry.valid && row_entry.ready)
				|| (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Receiver: random back-pressure, a quiet stretch, and one long hold-off
	// counted here so the sender keeps offering cells into a full pipeline.
	initial begin
		row_entry.ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
				row_entry.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				row_entry.ready <= 1'b0;
			end else begin
				row_entry.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	function automatic coeff_t rand_coeff();
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			4: return coeff_t'($urandom_range(4 * 65536)) - coeff_t'(2 * 65536);
			default: return coeff_t'($urandom);
		endcase
	endfunction

	// Mostly small extents keep frames short so the last-cell restart comes often.
	function automatic logic [GRID_REG_W-1:0] rand_extent();
		case ($urandom_range(19))
			0: return '0;
			1: return GRID_REG_W'(MAX_EXTENT);
			2: return GRID_REG_W'($urandom_range(511, MAX_EXTENT + 1));
			3: return GRID_REG_W'($urandom_range(511));
			default: return GRID_REG_W'($urandom_range(4, 1));
		endcase
	endfunction

	task automatic csr_write(input reg_index_t idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Grid writes carry random junk above the register width.
	task automatic write_grid(input logic [GRID_REG_W-1:0] gx, input logic [GRID_REG_W-1:0] gy,
			input logic [GRID_REG_W-1:0] gz);
		csr_write(REG_GRID_X, {23'($urandom), gx});
		csr_write(REG_GRID_Y, {23'($urandom), gy});
		csr_write(REG_GRID_Z, {23'($urandom), gz});
	endtask

	// Offer one cell request and hold it until accepted; valid stays high
	// into the next request unless a random gap is drawn.
	task automatic send_cell(input coeff_t centre, input coeff_t east, input coeff_t west,
			input coeff_t north, input coeff_t south, input coeff_t top, input coeff_t bottom);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			cell_req.valid <= 1'b0;
			@(posedge clk);
		end
		cell_req.valid        <= 1'b1;
		cell_req.centre_coeff <= centre;
		cell_req.east_coeff   <= east;
		cell_req.west_coeff   <= west;
		cell_req.north_coeff  <= north;
		cell_req.south_coeff  <= south;
		cell_req.top_coeff    <= top;
		cell_req.bottom_coeff <= bottom;
		do @(posedge clk); while (!cell_req.ready);
	endtask

	task automatic send_random_cell();
		send_cell(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
			rand_coeff(), rand_coeff());
	endtask

	// Drop valid, wait for every predicted entry, then let the pipeline settle
	// so a register write lands on an idle block.
	task automatic drain();
		cell_req.valid <= 1'b0;
		@(posedge clk);
		while (pending_entries != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sent;
		int phase;
		int burst;
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		cell_req.valid        <= 1'b0;
		cell_req.centre_coeff <= '0;
		cell_req.east_coeff   <= '0;
		cell_req.west_coeff   <= '0;
		cell_req.north_coeff  <= '0;
		cell_req.south_coeff  <= '0;
		cell_req.top_coeff    <= '0;
		cell_req.bottom_coeff <= '0;
		quiet = 1'b0;
		hold_off_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset grid is 1x1x1 and periodic: all six neighbors fold onto the
		// diagonal column, so each row is seven entries on column zero.
		send_cell(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_cell(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		drain();

		// 2x2x1, x periodic with extent two, y and z Dirichlet; run past the
		// last cell to see the frame restart.
		write_grid(GRID_REG_W'(2), GRID_REG_W'(2), GRID_REG_W'(1));
		csr_write(REG_BOUNDARY_MODES, DATA_W'(12'h550));
		send_cell(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
			32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
		send_cell(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
		repeat (3) send_random_cell();
		drain();

		// Out-of-range extents (zero acts as one, above max clamps), mode code 3
		// on every side, then a boundary-only write that must not restart.
		write_grid(GRID_REG_W'(0), GRID_REG_W'(300), GRID_REG_W'(511));
		csr_write(REG_BOUNDARY_MODES, DATA_W'(12'hFFF));
		repeat (3) send_random_cell();
		drain();
		csr_write(REG_BOUNDARY_MODES, DATA_W'(12'h9A6));
		repeat (3) send_random_cell();
		drain();

		// 3x1x1 with Neumann on x-high only; wraps once.
		write_grid(GRID_REG_W'(3), GRID_REG_W'(1), GRID_REG_W'(1));
		csr_write(REG_BOUNDARY_MODES, DATA_W'(12'h008));
		repeat (4) send_random_cell();

		// Random phases: fresh settings each time, one long receiver hold-off
		// in phase one and a stretch with no idling in phase two.
		sent = 0;
		phase = 0;
		while (sent < RANDOM_CELLS) begin
			drain();
			if (phase == 0 || $urandom_range(3) != 0)
				write_grid(rand_extent(), rand_extent(), rand_extent());
			case ($urandom_range(5))
				0: csr_write(REG_BOUNDARY_MODES, DATA_W'(12'h000));
				1: csr_write(REG_BOUNDARY_MODES, DATA_W'(12'hFFF));
				default: csr_write(REG_BOUNDARY_MODES, DATA_W'($urandom));
			endcase
			burst = (phase == 1 || phase == 2) ? 24 : $urandom_range(24, 4);
			quiet = (phase == 2);
			if (phase == 1)
				hold_off_req = 1'b1;
			repeat (burst) begin
				send_random_cell();
				sent++;
			end
			phase++;
		end
		drain();
		quiet = 1'b0;

		if (fail_count == 0 && pending_entries == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
